### rtl/playfair_digraph_encrypt_unit_assert.svh
// Assertion macros used by the block's top RTL file.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_UNIT_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDE_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define PDE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

### rtl/pde_pkg.sv
`default_nettype none
package pde_pkg;

    localparam int LW          = 5;
    localparam int LETTERS     = 26;
    localparam int CELLS       = 25;
    localparam int KEY_MAX_DEF = 10;

    localparam logic [LW-1:0] LET_I    = 5'd8;
    localparam logic [LW-1:0] LET_J    = 5'd9;
    localparam logic [LW-1:0] LET_X    = 5'd23;
    localparam logic [LW-1:0] LET_LAST = 5'd25;

    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_MSG    = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    localparam logic [1:0] ST_CIPHER = 2'd0;
    localparam logic [1:0] ST_READY  = 2'd1;
    localparam logic [1:0] ST_LONG   = 2'd2;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } rowcol_t;

    function automatic rowcol_t place_rc(input logic [LW-1:0] p);
        logic [LW-1:0] q;
        logic [LW-1:0] base;
        rowcol_t       rc;
        q = (p >= 5'd25) ? p - 5'd25 : p;
        priority if (q >= 5'd20) begin
            rc.row = 3'd4;
            base   = 5'd20;
        end else if (q >= 5'd15) begin
            rc.row = 3'd3;
            base   = 5'd15;
        end else if (q >= 5'd10) begin
            rc.row = 3'd2;
            base   = 5'd10;
        end else if (q >= 5'd5) begin
            rc.row = 3'd1;
            base   = 5'd5;
        end else begin
            rc.row = 3'd0;
            base   = 5'd0;
        end
        rc.col = 3'(q - base);
        return rc;
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [LW-1:0] cell_of(input logic [2:0] row, input logic [2:0] col);
        return 5'({row, 2'b00}) + 5'(row) + 5'(col);
    endfunction

endpackage
`default_nettype wire

### rtl/pde_ram.sv
`default_nettype none
module pde_ram #(
    parameter int WIDTH = pde_pkg::LW,
    parameter int DEPTH = pde_pkg::CELLS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/playfair_digraph_encrypt_unit.sv
// Channel   Dir  Word fields, lowest bit up                Side band
// s_*       in   tdata: letter[4:0], zero[7:5]              tuser: op
// m_*       out  tdata: cipher_letter[4:0], zero[7:5]       tlast: last, tuser: status
//
// A key letter passes through S_KEY before the next word is taken; a first message letter is only held.
// A finish walks the alphabet once, one letter a cycle, then reports its status.
// A pair steps through S_PA, S_PB, S_CALC, S_KA, S_OA, S_KB, S_OB, set by the single RAM read ports.
// Reset is synchronous and active low; the RAM contents are not cleared.
// A stalled result holds the sequencer until m_tready takes it.
`default_nettype none
`include "playfair_digraph_encrypt_unit_assert.svh"
module playfair_digraph_encrypt_unit #(
    parameter int KEY_MAX = pde_pkg::KEY_MAX_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // letter[4:0], zero[7:5]
    input  wire logic [1:0] s_tuser,   // op[1:0]
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // cipher_letter[4:0], zero[7:5]
    output logic            m_tlast,
    output logic [1:0]      m_tuser    // status[1:0]
);

    localparam int LW  = pde_pkg::LW;
    localparam int KCW = $clog2(KEY_MAX + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_KEY  = 4'd1;
    localparam logic [3:0] S_FILL = 4'd2;
    localparam logic [3:0] S_STAT = 4'd3;
    localparam logic [3:0] S_PA   = 4'd4;
    localparam logic [3:0] S_PB   = 4'd5;
    localparam logic [3:0] S_CALC = 4'd6;
    localparam logic [3:0] S_KA   = 4'd7;
    localparam logic [3:0] S_OA   = 4'd8;
    localparam logic [3:0] S_KB   = 4'd9;
    localparam logic [3:0] S_OB   = 4'd10;

    logic [3:0]                state_reg, state_next;
    logic [pde_pkg::LETTERS-1:0] used_reg, used_next;
    logic [LW-1:0]             fill_count_reg, fill_count_next;
    logic [KCW-1:0]            key_count_reg, key_count_next;
    logic                      held_valid_reg, held_valid_next;
    logic [LW-1:0]             held_letter_reg, held_letter_next;
    logic                      out_valid_reg, out_valid_next;

    logic [LW-1:0]             let_reg, let_next;
    logic [LW-1:0]             fill_k_reg, fill_k_next;
    logic [1:0]                status_reg, status_next;
    logic [LW-1:0]             pa_reg, pa_next;
    logic [LW-1:0]             pb_reg, pb_next;
    logic [2:0]                ra_reg, ra_next;
    logic [2:0]                ca_reg, ca_next;
    logic [LW-1:0]             ea_reg, ea_next;
    logic [LW-1:0]             eb_reg, eb_next;
    logic [LW-1:0]             out_letter_reg, out_letter_next;
    logic                      out_last_reg, out_last_next;
    logic [1:0]                out_status_reg, out_status_next;

    logic [1:0]      in_op;
    logic [LW-1:0]   in_letter;
    logic            accept;
    logic            out_free;
    logic [LW-1:0]   place_letter;
    logic            place_en;
    logic [LW-1:0]   place_raddr;
    logic [LW-1:0]   place_rdata;
    logic [LW-1:0]   key_raddr;
    logic [LW-1:0]   key_rdata;
    pde_pkg::rowcol_t rc;

    assign in_op     = s_tuser;
    assign in_letter = (s_tdata[4:0] == pde_pkg::LET_J) ? pde_pkg::LET_I : s_tdata[4:0];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign place_letter = (state_reg == S_FILL) ? fill_k_reg : let_reg;
    assign place_en     = ((state_reg == S_KEY) || (state_reg == S_FILL)) &&
                          (fill_count_reg < 5'(pde_pkg::CELLS)) && !used_reg[place_letter];
    assign place_raddr  = (state_reg == S_PB) ? pb_reg : pa_reg;
    assign key_raddr    = ((state_reg == S_KB) || (state_reg == S_OB)) ? eb_reg : ea_reg;
    assign rc           = pde_pkg::place_rc(place_rdata);

    pde_ram #(
        .WIDTH(LW),
        .DEPTH(pde_pkg::CELLS)
    ) u_square (
        .clk  (aclk),
        .we   (place_en),
        .waddr(fill_count_reg),
        .wdata(place_letter),
        .raddr(key_raddr),
        .rdata(key_rdata)
    );

    pde_ram #(
        .WIDTH(LW),
        .DEPTH(pde_pkg::LETTERS)
    ) u_place (
        .clk  (aclk),
        .we   (place_en),
        .waddr(place_letter),
        .wdata(fill_count_reg),
        .raddr(place_raddr),
        .rdata(place_rdata)
    );

    always_comb begin
        state_next       = state_reg;
        used_next        = used_reg;
        fill_count_next  = fill_count_reg;
        key_count_next   = key_count_reg;
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        let_next         = let_reg;
        fill_k_next      = fill_k_reg;
        status_next      = status_reg;
        pa_next          = pa_reg;
        pb_next          = pb_reg;
        ra_next          = ra_reg;
        ca_next          = ca_reg;
        ea_next          = ea_reg;
        eb_next          = eb_reg;
        out_letter_next  = out_letter_reg;
        out_last_next    = out_last_reg;
        out_status_next  = out_status_reg;

        if (place_en) begin
            used_next[place_letter] = 1'b1;
            fill_count_next         = fill_count_reg + 5'd1;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        pde_pkg::OP_KEY: begin
                            if (in_letter <= pde_pkg::LET_LAST) begin
                                if (key_count_reg >= KCW'(KEY_MAX)) begin
                                    status_next = pde_pkg::ST_LONG;
                                    state_next  = S_STAT;
                                end else begin
                                    key_count_next = key_count_reg + KCW'(1);
                                    let_next       = in_letter;
                                    state_next     = S_KEY;
                                end
                            end
                        end
                        pde_pkg::OP_FINISH: begin
                            fill_k_next = '0;
                            state_next  = S_FILL;
                        end
                        pde_pkg::OP_MSG: begin
                            if (in_letter <= pde_pkg::LET_LAST) begin
                                if (!held_valid_reg) begin
                                    held_valid_next  = 1'b1;
                                    held_letter_next = in_letter;
                                end else if (held_letter_reg == in_letter) begin
                                    pa_next    = held_letter_reg;
                                    pb_next    = pde_pkg::LET_X;
                                    state_next = S_PA;
                                end else begin
                                    pa_next          = held_letter_reg;
                                    pb_next          = in_letter;
                                    held_valid_next  = 1'b0;
                                    held_letter_next = '0;
                                    state_next       = S_PA;
                                end
                            end
                        end
                        pde_pkg::OP_END: begin
                            if (held_valid_reg) begin
                                pa_next          = held_letter_reg;
                                pb_next          = pde_pkg::LET_X;
                                held_valid_next  = 1'b0;
                                held_letter_next = '0;
                                state_next       = S_PA;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_KEY: begin
                state_next = S_IDLE;
            end
            S_FILL: begin
                if (fill_k_reg == pde_pkg::LET_LAST) begin
                    status_next = pde_pkg::ST_READY;
                    state_next  = S_STAT;
                end else begin
                    fill_k_next = fill_k_reg + 5'd1;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_letter_next = '0;
                    out_last_next   = 1'b1;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            S_PA: begin
                state_next = S_PB;
            end
            S_PB: begin
                ra_next    = rc.row;
                ca_next    = rc.col;
                state_next = S_CALC;
            end
            S_CALC: begin
                if (ca_reg == rc.col) begin
                    ea_next = pde_pkg::cell_of(pde_pkg::wrap_inc(ra_reg), ca_reg);
                    eb_next = pde_pkg::cell_of(pde_pkg::wrap_inc(rc.row), rc.col);
                end else if (ra_reg == rc.row) begin
                    ea_next = pde_pkg::cell_of(ra_reg, pde_pkg::wrap_inc(ca_reg));
                    eb_next = pde_pkg::cell_of(rc.row, pde_pkg::wrap_inc(rc.col));
                end else begin
                    ea_next = pde_pkg::cell_of(ra_reg, rc.col);
                    eb_next = pde_pkg::cell_of(rc.row, ca_reg);
                end
                state_next = S_KA;
            end
            S_KA: begin
                state_next = S_OA;
            end
            S_OA: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_letter_next = key_rdata;
                    out_last_next   = 1'b0;
                    out_status_next = pde_pkg::ST_CIPHER;
                    state_next      = S_KB;
                end
            end
            S_KB: begin
                state_next = S_OB;
            end
            S_OB: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_letter_next = key_rdata;
                    out_last_next   = 1'b1;
                    out_status_next = pde_pkg::ST_CIPHER;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            used_reg        <= pde_pkg::LETTERS'(1) << pde_pkg::LET_J;
            fill_count_reg  <= '0;
            key_count_reg   <= '0;
            held_valid_reg  <= 1'b0;
            held_letter_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            fill_count_reg  <= fill_count_next;
            key_count_reg   <= key_count_next;
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        let_reg        <= let_next;
        fill_k_reg     <= fill_k_next;
        status_reg     <= status_next;
        pa_reg         <= pa_next;
        pb_reg         <= pb_next;
        ra_reg         <= ra_next;
        ca_reg         <= ca_next;
        ea_reg         <= ea_next;
        eb_reg         <= eb_next;
        out_letter_reg <= out_letter_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_letter_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

    `PDE_ASSERT_SAME(a_fill_bound, aclk, aresetn, 1'b1, fill_count_reg <= 5'(pde_pkg::CELLS))
    `PDE_ASSERT_SAME(a_key_bound, aclk, aresetn, 1'b1, key_count_reg <= KCW'(KEY_MAX))
    `PDE_ASSERT_SAME(a_status_last, aclk, aresetn, m_tvalid && (m_tuser != pde_pkg::ST_CIPHER), m_tlast)
    `PDE_ASSERT_NEXT(a_pair_second, aclk, aresetn, (state_reg == S_OA) && out_free, state_reg == S_KB)

endmodule
`default_nettype wire

### verif/pde_cipher_checker.sv
`default_nettype none
module pde_cipher_checker #(
    parameter int KEY_MAX = pde_pkg::KEY_MAX_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,   // letter[4:0], zero[7:5]
    input  wire logic [1:0] s_tuser,   // op[1:0]
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,   // cipher_letter[4:0], zero[7:5]
    input  wire logic       m_tlast,
    input  wire logic [1:0] m_tuser,   // status[1:0]
    output int              mismatch_count,
    output int              words_due
);

    localparam int LW = pde_pkg::LW;

    typedef struct packed {
        logic [LW-1:0] letter;
        logic          last;
        logic [1:0]    status;
    } cipher_word_t;

    cipher_word_t       due_words[$];
    logic [LW-1:0]      square_cell[pde_pkg::CELLS];
    logic [LW-1:0]      letter_cell[pde_pkg::LETTERS];
    logic [pde_pkg::LETTERS-1:0] placed;
    int                 filled;
    int                 keys_taken;
    logic               holding;
    logic [LW-1:0]      held;
    int                 errors = 0;
    int                 due = 0;

    assign mismatch_count = errors;
    assign words_due      = due;

    function automatic void place_in_square(input logic [LW-1:0] c);
        if (c > pde_pkg::LET_LAST || filled >= pde_pkg::CELLS) begin
            return;
        end
        if (placed[c]) begin
            return;
        end
        square_cell[filled] = c;
        letter_cell[c]      = LW'(filled);
        placed[c]           = 1'b1;
        filled++;
    endfunction

    function automatic void push_status(input logic [1:0] status);
        cipher_word_t w;
        w.letter = '0;
        w.last   = 1'b1;
        w.status = status;
        due_words.push_back(w);
    endfunction

    function automatic void encipher_pair(input logic [LW-1:0] a, input logic [LW-1:0] b);
        int           pa, pb, ra, ca, rb, cb, ea, eb;
        cipher_word_t w;
        pa = int'(letter_cell[a]) % 25;
        pb = int'(letter_cell[b]) % 25;
        ra = pa / 5;
        ca = pa % 5;
        rb = pb / 5;
        cb = pb % 5;
        if (ca == cb) begin
            ea = ((ra + 1) % 5) * 5 + ca;
            eb = ((rb + 1) % 5) * 5 + cb;
        end else if (ra == rb) begin
            ea = ra * 5 + (ca + 1) % 5;
            eb = rb * 5 + (cb + 1) % 5;
        end else begin
            ea = ra * 5 + cb;
            eb = rb * 5 + ca;
        end
        w.letter = square_cell[ea];
        w.last   = 1'b0;
        w.status = pde_pkg::ST_CIPHER;
        due_words.push_back(w);
        w.letter = square_cell[eb];
        w.last   = 1'b1;
        due_words.push_back(w);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin : track
        cipher_word_t  want;
        logic [1:0]    op;
        logic [LW-1:0] c;
        if (!aresetn) begin
            due_words.delete();
            foreach (square_cell[i]) begin
                square_cell[i] = '0;
            end
            foreach (letter_cell[i]) begin
                letter_cell[i] = '0;
            end
            placed     = '0;
            placed[pde_pkg::LET_J] = 1'b1;
            filled     = 0;
            keys_taken = 0;
            holding    = 1'b0;
            held       = '0;
        end else begin
            // Results are matched before new words are predicted, so a stray result
            // in the cycle of an input word is still caught.
            if (m_tvalid && m_tready) begin
                if (due_words.size() == 0) begin
                    report_mismatch("word with nothing due, tdata", int'(m_tdata), 0);
                end else begin
                    want = due_words.pop_front();
                    if (m_tdata !== 8'(want.letter)) begin
                        report_mismatch("cipher letter", int'(m_tdata), int'(want.letter));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch("tlast", int'(m_tlast), int'(want.last));
                    end
                    if (m_tuser !== want.status) begin
                        report_mismatch("status", int'(m_tuser), int'(want.status));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                op = s_tuser;
                c  = s_tdata[4:0];
                if (c == pde_pkg::LET_J) begin
                    c = pde_pkg::LET_I;
                end
                case (op)
                    pde_pkg::OP_KEY: begin
                        if (c <= pde_pkg::LET_LAST) begin
                            if (keys_taken >= KEY_MAX) begin
                                push_status(pde_pkg::ST_LONG);
                            end else begin
                                keys_taken++;
                                place_in_square(c);
                            end
                        end
                    end
                    pde_pkg::OP_FINISH: begin
                        for (int k = 0; k < pde_pkg::LETTERS; k++) begin
                            place_in_square(LW'(k));
                        end
                        push_status(pde_pkg::ST_READY);
                    end
                    pde_pkg::OP_MSG: begin
                        if (c <= pde_pkg::LET_LAST) begin
                            if (!holding) begin
                                holding = 1'b1;
                                held    = c;
                            end else if (held == c) begin
                                encipher_pair(held, pde_pkg::LET_X);
                            end else begin
                                encipher_pair(held, c);
                                holding = 1'b0;
                                held    = '0;
                            end
                        end
                    end
                    default: begin
                        if (holding) begin
                            encipher_pair(held, pde_pkg::LET_X);
                            holding = 1'b0;
                            held    = '0;
                        end
                    end
                endcase
            end
        end
        due <= due_words.size();
    end

endmodule
`default_nettype wire

### verif/playfair_digraph_encrypt_unit_tb.sv
`default_nettype none
module playfair_digraph_encrypt_unit_tb;

    localparam int LW           = pde_pkg::LW;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_WORDS = 1575;
    localparam int CALM_WORDS   = 200;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic [7:0]    s_tdata  = '0;
    logic [1:0]    s_tuser  = '0;
    logic          m_tready = 1'b0;
    wire logic     s_tready;
    wire logic     m_tvalid;
    wire logic [7:0] m_tdata;
    wire logic     m_tlast;
    wire logic [1:0] m_tuser;
    int            mismatch_count;
    int            words_due;
    logic          calm      = 1'b0;
    logic          long_stall = 1'b0;
    logic [LW-1:0] last_msg  = '0;

    playfair_digraph_encrypt_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    pde_cipher_checker #(
        .KEY_MAX (pde_pkg::KEY_MAX_DEF)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .words_due      (words_due)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : result_sink
        bit stalled_once;
        stalled_once = 1'b0;
        forever begin
            if (long_stall && !stalled_once) begin
                stalled_once = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [LW-1:0] letter);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, letter};
        s_tuser  <= op;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic wait_words_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_due != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin : stimulus
        int            r;
        int            s;
        logic [1:0]    op;
        logic [LW-1:0] letter;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Before the square is finished only words that never read it are sent.
        send_word(pde_pkg::OP_END, 5'd0);
        send_word(pde_pkg::OP_MSG, 5'd31);
        send_word(pde_pkg::OP_KEY, pde_pkg::LET_J);
        send_word(pde_pkg::OP_KEY, pde_pkg::LET_LAST);
        send_word(pde_pkg::OP_KEY, 5'd0);
        send_word(pde_pkg::OP_KEY, 5'd31);
        send_word(pde_pkg::OP_KEY, pde_pkg::LET_J);
        repeat (4) send_word(pde_pkg::OP_KEY, LW'($urandom_range(0, 25)));
        send_word(pde_pkg::OP_KEY, pde_pkg::LET_X);
        send_word(pde_pkg::OP_KEY, LW'($urandom_range(0, 25)));
        send_word(pde_pkg::OP_KEY, 5'd2);
        send_word(pde_pkg::OP_FINISH, 5'd31);
        send_word(pde_pkg::OP_FINISH, 5'd0);
        send_word(pde_pkg::OP_MSG, pde_pkg::LET_X);
        send_word(pde_pkg::OP_MSG, pde_pkg::LET_X);
        send_word(pde_pkg::OP_END, 5'd0);
        send_word(pde_pkg::OP_MSG, pde_pkg::LET_J);
        send_word(pde_pkg::OP_MSG, pde_pkg::LET_I);
        send_word(pde_pkg::OP_MSG, 5'd0);
        send_word(pde_pkg::OP_MSG, pde_pkg::LET_LAST);
        send_word(pde_pkg::OP_END, 5'd31);
        send_word(pde_pkg::OP_END, 5'd0);

        long_stall <= 1'b1;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == 700) begin
                wait_words_done();
            end
            if (i == RANDOM_WORDS - CALM_WORDS) begin
                calm <= 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 62) begin
                op = pde_pkg::OP_MSG;
                s  = $urandom_range(0, 9);
                if (s < 2) begin
                    letter = last_msg;
                end else if (s == 2) begin
                    letter = pde_pkg::LET_X;
                end else if (s == 3) begin
                    letter = pde_pkg::LET_J;
                end else begin
                    letter = LW'($urandom_range(0, 25));
                end
                last_msg = letter;
            end else if (r < 67) begin
                op     = pde_pkg::OP_MSG;
                letter = LW'($urandom_range(26, 31));
            end else if (r < 82) begin
                op     = pde_pkg::OP_END;
                letter = LW'($urandom_range(0, 31));
            end else if (r < 92) begin
                op     = pde_pkg::OP_KEY;
                letter = LW'($urandom_range(0, 31));
            end else begin
                op     = pde_pkg::OP_FINISH;
                letter = LW'($urandom_range(0, 31));
            end
            send_word(op, letter);
        end

        wait_words_done();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/pde_pkg.sv
rtl/pde_ram.sv
rtl/playfair_digraph_encrypt_unit.sv
verif/pde_cipher_checker.sv
verif/playfair_digraph_encrypt_unit_tb.sv
